// ===== rtl/touch_report_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// touch report parser assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TOUCH_REPORT_PARSER_CORE_MACROS_SVH
`define TOUCH_REPORT_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property checked while reset is low
`define TRP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every edge, reset included
`define TRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRP_ASSERT(lbl, clk, rst, prop, msg)
`define TRP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/trp_pkg.sv =====
// ----------------------------------------------------------------------------
// touch report parser package
// shared widths, codes and types of the touch report parser
// ----------------------------------------------------------------------------
package trp_pkg;

   // default contact store depth
   localparam int MAX_CONTACTS_DEF = 10;

   // payload widths
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int MODE_W    = 2;
   localparam int COORD_W   = 16;
   localparam int CSR_IDX_W = 2;

   // read format codes
   localparam logic [1:0] FMT_UNDECIDED = 2'd0;
   localparam logic [1:0] FMT_SINGLE    = 2'd1;
   localparam logic [1:0] FMT_MULTI     = 2'd2;

   // frame kind codes
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MULTI  = 2'd2;

   // contact mode codes
   localparam logic [MODE_W-1:0] MODE_DOWN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MOVE = 2'd2;

   // mode byte values of single-contact reports
   localparam logic [BYTE_W-1:0] MODE_BYTE_DOWN = 8'h01;
   localparam logic [BYTE_W-1:0] MODE_BYTE_UP   = 8'h02;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SINGLE_ID    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MULTI_ID     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MULTI_ALT_ID = 2'd2;

   // register reset values
   localparam logic [BYTE_W-1:0] SINGLE_ID_RST    = 8'd144;
   localparam logic [BYTE_W-1:0] MULTI_ID_RST     = 8'd12;
   localparam logic [BYTE_W-1:0] MULTI_ALT_ID_RST = 8'd3;

   // single report byte positions
   localparam logic [3:0] SPOS_ID    = 4'd0;
   localparam logic [3:0] SPOS_FIRST = 4'd2;
   localparam logic [3:0] SPOS_LAST  = 4'd10;

   // multitouch header positions
   localparam logic [3:0] MPOS_ID      = 4'd0;
   localparam logic [3:0] MPOS_PAD     = 4'd1;
   localparam logic [3:0] MPOS_COUNT   = 4'd2;
   localparam logic [3:0] MPOS_CONTACT = 4'd3;

   // last byte within a multitouch contact
   localparam logic [2:0] MSUB_LAST = 3'd6;

   typedef struct packed {
      logic [BYTE_W-1:0]  slot;
      logic [MODE_W-1:0]  mode;
      logic               new_action;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } contact_type;

   typedef struct packed {
      logic [BYTE_W-1:0] single_id;
      logic [BYTE_W-1:0] multi_id;
      logic [BYTE_W-1:0] multi_alt_id;
   } cfg_type;

   // end-of-read handoff from parser to result buffer
   typedef struct packed {
      logic              load;
      logic              status;
      logic [KIND_W-1:0] kind;
   } snap_type;

endpackage

// ===== rtl/trp_req_if.sv =====
// ----------------------------------------------------------------------------
// touch report parser byte channel
// valid/ready channel carrying one read byte and its end marker per beat
// ----------------------------------------------------------------------------
interface trp_req_if;
   logic                       valid;
   logic                       ready;
   logic [trp_pkg::BYTE_W-1:0] data_byte;
   logic                       end_of_read;

   modport source (output valid, output data_byte, output end_of_read, input ready);
   modport sink (input valid, input data_byte, input end_of_read, output ready);
endinterface

// ===== rtl/trp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// touch report parser result channel
// valid/ready channel carrying one decoded contact per beat
// ----------------------------------------------------------------------------
interface trp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic [trp_pkg::KIND_W-1:0]  frame_kind;
   logic                        has_contact;
   logic [trp_pkg::BYTE_W-1:0]  contact_slot;
   logic [trp_pkg::MODE_W-1:0]  contact_mode;
   logic                        new_action;
   logic [trp_pkg::COORD_W-1:0] raw_x;
   logic [trp_pkg::COORD_W-1:0] raw_y;
   logic [trp_pkg::COORD_W-1:0] raw_z;
   logic                        last_item;

   modport source (output valid, output status, output frame_kind, output has_contact,
                   output contact_slot, output contact_mode, output new_action,
                   output raw_x, output raw_y, output raw_z, output last_item,
                   input ready);
   modport sink (input valid, input status, input frame_kind, input has_contact,
                 input contact_slot, input contact_mode, input new_action,
                 input raw_x, input raw_y, input raw_z, input last_item,
                 output ready);
endinterface

// ===== rtl/trp_csr_if.sv =====
// ----------------------------------------------------------------------------
// touch report parser register write channel
// valid/ready channel carrying a register index and write data per beat
// ----------------------------------------------------------------------------
interface trp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [trp_pkg::CSR_IDX_W-1:0] index;
   logic [trp_pkg::BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/trp_csr.sv =====
// ----------------------------------------------------------------------------
// touch report parser registers
// report id registers written over the register channel
// ----------------------------------------------------------------------------
module trp_csr (
   input  logic              clock,
   input  logic              reset,
   trp_csr_if.sink           csr_chan,
   output trp_pkg::cfg_type  cfg
);

   trp_pkg::cfg_type cfg_ff;
   trp_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_chan.ready = 1'b1;

   // register decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            trp_pkg::REG_SINGLE_ID:    cfg_in.single_id    = csr_chan.data;
            trp_pkg::REG_MULTI_ID:     cfg_in.multi_id     = csr_chan.data;
            trp_pkg::REG_MULTI_ALT_ID: cfg_in.multi_alt_id = csr_chan.data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.single_id    <= trp_pkg::SINGLE_ID_RST;
         cfg_ff.multi_id     <= trp_pkg::MULTI_ID_RST;
         cfg_ff.multi_alt_id <= trp_pkg::MULTI_ALT_ID_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/trp_parse.sv =====
// ----------------------------------------------------------------------------
// touch report parser byte decoder
// per-byte report parsing, contact store and multitouch commit store
// ----------------------------------------------------------------------------
module trp_parse #(
   parameter int MAX_CONTACTS = trp_pkg::MAX_CONTACTS_DEF,
   parameter int CW           = $clog2(MAX_CONTACTS + 1),
   parameter int IW           = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  trp_pkg::cfg_type           cfg,
   input  logic                       beat,
   input  logic [trp_pkg::BYTE_W-1:0] data_byte,
   input  logic                       end_of_read,
   output trp_pkg::snap_type          snap,
   output logic [CW-1:0]              snap_count,
   output trp_pkg::contact_type       snap_list [MAX_CONTACTS]
);

   // per-read control state
   logic [3:0]  pos_ff, pos_in;
   logic [1:0]  fmt_ff, fmt_in;
   logic        stop_ff, stop_in;
   logic [7:0]  hc_ff, hc_in;
   logic [2:0]  sub_ff, sub_in;
   logic [7:0]  k_ff, k_in;
   logic [CW-1:0] wc_ff, wc_in;
   logic [CW-1:0] cc_ff, cc_in;
   logic [trp_pkg::KIND_W-1:0] ck_ff, ck_in;
   logic        any_ff, any_in;

   // byte assembly and contact stores
   logic [7:0]  asm_ff [8];
   logic        asm_wr;
   logic [2:0]  asm_idx;
   trp_pkg::contact_type work_ff [MAX_CONTACTS];
   trp_pkg::contact_type comm_ff [MAX_CONTACTS];
   trp_pkg::contact_type work_in [MAX_CONTACTS];
   trp_pkg::contact_type comm_in [MAX_CONTACTS];

   logic        is_multi_id;
   logic [1:0]  fmt_cur;
   logic        wr_en;
   logic [IW-1:0] wr_idx;
   logic        commit;
   trp_pkg::contact_type single_entry;
   trp_pkg::contact_type multi_entry;
   trp_pkg::contact_type wr_entry;

   assign is_multi_id = (data_byte == cfg.multi_id) || (data_byte == cfg.multi_alt_id);
   assign fmt_cur     = (fmt_ff == trp_pkg::FMT_UNDECIDED)
                        ? (is_multi_id ? trp_pkg::FMT_MULTI : trp_pkg::FMT_SINGLE) : fmt_ff;

   // single-contact entry from the assembled bytes and the z high byte
   always_comb begin
      single_entry.slot = asm_ff[0];
      if (asm_ff[1] == trp_pkg::MODE_BYTE_DOWN) begin
         single_entry.mode = trp_pkg::MODE_DOWN;
      end else if (asm_ff[1] == trp_pkg::MODE_BYTE_UP) begin
         single_entry.mode = trp_pkg::MODE_UP;
      end else begin
         single_entry.mode = trp_pkg::MODE_MOVE;
      end
      single_entry.new_action = (asm_ff[2] == 8'd0);
      single_entry.x = {asm_ff[4], asm_ff[3]};
      single_entry.y = {asm_ff[6], asm_ff[5]};
      single_entry.z = {data_byte, asm_ff[7]};
   end

   // multitouch entry: x and y swapped, bad id falls back to the index
   always_comb begin
      multi_entry.slot = (asm_ff[1] < 8'(MAX_CONTACTS)) ? asm_ff[1] : k_ff;
      multi_entry.mode = asm_ff[0][0] ? trp_pkg::MODE_MOVE : trp_pkg::MODE_UP;
      multi_entry.new_action = 1'b0;
      multi_entry.x = {data_byte, asm_ff[5]};
      multi_entry.y = {asm_ff[4], asm_ff[3]};
      multi_entry.z = '0;
   end

   // report parsing for one byte
   always_comb begin
      pos_in   = pos_ff;
      fmt_in   = fmt_cur;
      stop_in  = stop_ff;
      hc_in    = hc_ff;
      sub_in   = sub_ff;
      k_in     = k_ff;
      wc_in    = wc_ff;
      asm_wr   = 1'b0;
      asm_idx  = sub_ff;
      wr_en    = 1'b0;
      wr_idx   = k_ff[IW-1:0];
      wr_entry = multi_entry;
      commit   = 1'b0;
      if (!stop_ff) begin
         if (fmt_cur == trp_pkg::FMT_MULTI) begin
            case (pos_ff)
               trp_pkg::MPOS_ID: begin
                  if (!is_multi_id) begin
                     stop_in = 1'b1;
                  end else begin
                     wc_in  = '0;
                     pos_in = trp_pkg::MPOS_PAD;
                  end
               end
               trp_pkg::MPOS_PAD: begin
                  pos_in = trp_pkg::MPOS_COUNT;
               end
               trp_pkg::MPOS_COUNT: begin
                  hc_in = data_byte;
                  if (data_byte == 8'd0) begin
                     commit = 1'b1;
                     pos_in = trp_pkg::MPOS_ID;
                  end else begin
                     pos_in = trp_pkg::MPOS_CONTACT;
                     sub_in = '0;
                     k_in   = '0;
                  end
               end
               default: begin
                  asm_wr = 1'b1;
                  if (sub_ff == trp_pkg::MSUB_LAST) begin
                     // contacts past the store are skipped
                     if (k_ff < hc_ff && k_ff < 8'(MAX_CONTACTS)) begin
                        wr_en = 1'b1;
                        wc_in = CW'(k_ff) + CW'(1);
                     end
                     if (k_ff == hc_ff - 8'd1) begin
                        commit = 1'b1;
                        pos_in = trp_pkg::MPOS_ID;
                     end else begin
                        sub_in = '0;
                        k_in   = k_ff + 8'd1;
                     end
                  end else begin
                     sub_in = sub_ff + 3'd1;
                  end
               end
            endcase
         end else begin
            wr_idx   = wc_ff[IW-1:0];
            wr_entry = single_entry;
            asm_idx  = 3'(pos_ff - trp_pkg::SPOS_FIRST);
            if (pos_ff == trp_pkg::SPOS_ID) begin
               if (data_byte != cfg.single_id || wc_ff >= CW'(MAX_CONTACTS)) begin
                  stop_in = 1'b1;
               end else begin
                  pos_in = pos_ff + 4'd1;
               end
            end else if (pos_ff == trp_pkg::SPOS_LAST) begin
               wr_en  = 1'b1;
               wc_in  = wc_ff + CW'(1);
               pos_in = trp_pkg::SPOS_ID;
            end else begin
               asm_wr = (pos_ff >= trp_pkg::SPOS_FIRST);
               pos_in = pos_ff + 4'd1;
            end
         end
      end
   end

   // store next values, commit copies the updated working store
   always_comb begin
      for (int i = 0; i < MAX_CONTACTS; i++) begin
         work_in[i] = (wr_en && wr_idx == IW'(i)) ? wr_entry : work_ff[i];
         comm_in[i] = commit ? work_in[i] : comm_ff[i];
      end
      cc_in  = commit ? wc_in : cc_ff;
      ck_in  = commit ? ((hc_in == 8'd0) ? trp_pkg::KIND_NONE : trp_pkg::KIND_MULTI) : ck_ff;
      any_in = commit | any_ff;
   end

   // end-of-read handoff
   always_comb begin
      snap.load = beat && end_of_read;
      if (fmt_cur == trp_pkg::FMT_MULTI) begin
         snap.status = !any_in;
         snap.kind   = any_in ? ck_in : trp_pkg::KIND_NONE;
         snap_count  = any_in ? cc_in : '0;
         snap_list   = comm_in;
      end else begin
         snap.status = 1'b0;
         snap.kind   = trp_pkg::KIND_SINGLE;
         snap_count  = wc_in;
         snap_list   = work_in;
      end
   end

   // control state, cleared at the end of every read
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fmt_ff  <= trp_pkg::FMT_UNDECIDED;
         stop_ff <= 1'b0;
         hc_ff   <= '0;
         sub_ff  <= '0;
         k_ff    <= '0;
         wc_ff   <= '0;
         cc_ff   <= '0;
         ck_ff   <= trp_pkg::KIND_NONE;
         any_ff  <= 1'b0;
      end else if (beat) begin
         if (end_of_read) begin
            pos_ff  <= '0;
            fmt_ff  <= trp_pkg::FMT_UNDECIDED;
            stop_ff <= 1'b0;
            hc_ff   <= '0;
            sub_ff  <= '0;
            k_ff    <= '0;
            wc_ff   <= '0;
            cc_ff   <= '0;
            ck_ff   <= trp_pkg::KIND_NONE;
            any_ff  <= 1'b0;
         end else begin
            pos_ff  <= pos_in;
            fmt_ff  <= fmt_in;
            stop_ff <= stop_in;
            hc_ff   <= hc_in;
            sub_ff  <= sub_in;
            k_ff    <= k_in;
            wc_ff   <= wc_in;
            cc_ff   <= cc_in;
            ck_ff   <= ck_in;
            any_ff  <= any_in;
         end
      end
   end

   // payload stores, no reset
   always_ff @(posedge clock) begin
      if (beat) begin
         if (asm_wr) begin
            asm_ff[asm_idx] <= data_byte;
         end
         work_ff <= work_in;
         comm_ff <= comm_in;
      end
   end

endmodule

// ===== rtl/trp_emit.sv =====
// ----------------------------------------------------------------------------
// touch report parser result buffer
// holds the contacts of one finished read and sends them one beat at a time
// ----------------------------------------------------------------------------
module trp_emit #(
   parameter int MAX_CONTACTS = trp_pkg::MAX_CONTACTS_DEF,
   parameter int CW           = $clog2(MAX_CONTACTS + 1),
   parameter int IW           = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  trp_pkg::snap_type    snap,
   input  logic [CW-1:0]        snap_count,
   input  trp_pkg::contact_type snap_list [MAX_CONTACTS],
   output logic                 busy,
   trp_rsp_if.source            rsp_chan
);

   logic                       busy_ff;
   logic [IW-1:0]              idx_ff;
   logic [CW-1:0]              n_ff;
   logic                       st_ff;
   logic [trp_pkg::KIND_W-1:0] kd_ff;
   trp_pkg::contact_type       buf_ff [MAX_CONTACTS];

   logic                 has;
   logic                 last;
   trp_pkg::contact_type ent;

   // current beat
   assign has  = (n_ff != '0);
   assign last = !has || ((CW'(idx_ff) + CW'(1)) == n_ff);
   assign ent  = has ? buf_ff[idx_ff] : '0;

   assign busy                  = busy_ff;
   assign rsp_chan.valid        = busy_ff;
   assign rsp_chan.status       = st_ff;
   assign rsp_chan.frame_kind   = kd_ff;
   assign rsp_chan.has_contact  = has;
   assign rsp_chan.contact_slot = ent.slot;
   assign rsp_chan.contact_mode = ent.mode;
   assign rsp_chan.new_action   = ent.new_action;
   assign rsp_chan.raw_x        = ent.x;
   assign rsp_chan.raw_y        = ent.y;
   assign rsp_chan.raw_z        = ent.z;
   assign rsp_chan.last_item    = last;

   // send sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (snap.load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_chan.ready) begin
         if (last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + IW'(1);
         end
      end
   end

   // snapshot of the read
   always_ff @(posedge clock) begin
      if (snap.load) begin
         n_ff   <= snap_count;
         st_ff  <= snap.status;
         kd_ff  <= snap.kind;
         buf_ff <= snap_list;
      end
   end

endmodule

// ===== rtl/touch_report_parser_core.sv =====
// ----------------------------------------------------------------------------
// touch report parser core
// decodes the touch contacts of one read, single-contact or multitouch format
// ----------------------------------------------------------------------------
// Each read byte is taken and decoded on the spot. On the final byte of a read
// its contacts are copied into a result buffer and sent one beat per cycle
// while the receiver is ready: one beat per contact, or a single beat when
// there is none, up to MAX_CONTACTS beats. Bytes may arrive on every cycle,
// also while the buffer drains; only the final byte of the next read waits
// until the last beat of the previous read has been taken. There is no
// start-up pass after reset. Register writes are meant for idle periods.
`include "touch_report_parser_core_macros.svh"

module touch_report_parser_core #(
   parameter int MAX_CONTACTS = trp_pkg::MAX_CONTACTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   trp_req_if.sink    req_chan,
   trp_rsp_if.source  rsp_chan,
   trp_csr_if.sink    csr_chan
);

   localparam int CW = $clog2(MAX_CONTACTS + 1);
   localparam int IW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

   trp_pkg::cfg_type     cfg;
   trp_pkg::snap_type    snap;
   logic [CW-1:0]        snap_count;
   trp_pkg::contact_type snap_list [MAX_CONTACTS];
   logic                 busy;
   logic                 beat;

   // a final byte waits for a free result buffer
   assign req_chan.ready = !(req_chan.end_of_read && busy);
   assign beat           = req_chan.valid && req_chan.ready;

   trp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   trp_parse #(
      .MAX_CONTACTS (MAX_CONTACTS),
      .CW           (CW),
      .IW           (IW)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .beat        (beat),
      .data_byte   (req_chan.data_byte),
      .end_of_read (req_chan.end_of_read),
      .snap        (snap),
      .snap_count  (snap_count),
      .snap_list   (snap_list)
   );

   trp_emit #(
      .MAX_CONTACTS (MAX_CONTACTS),
      .CW           (CW),
      .IW           (IW)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .snap       (snap),
      .snap_count (snap_count),
      .snap_list  (snap_list),
      .busy       (busy),
      .rsp_chan   (rsp_chan)
   );

   // checks
   `TRP_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_chan.valid, "results after reset")
   `TRP_ASSERT(a_eor_gives_result, clock, reset, beat && req_chan.end_of_read |=> rsp_chan.valid, "final byte gave no result")
   `TRP_ASSERT(a_no_eor_while_busy, clock, reset, rsp_chan.valid |-> !(beat && req_chan.end_of_read), "final byte taken over pending results")
   `TRP_ASSERT(a_empty_is_last, clock, reset, rsp_chan.valid && !rsp_chan.has_contact |-> rsp_chan.last_item, "empty result not last")

endmodule
